// ===== rtl/rlmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rlmf_pkg
// Shared types and constants of the rotating LED matrix framebuffer.
// ----------------------------------------------------------------------------
package rlmf_pkg;

    localparam int unsigned NUM_ROWS = 8;

    localparam logic [7:0] ROW_ALL_ON  = 8'hFF;
    localparam logic [7:0] ROW_ALL_OFF = 8'h00;
    localparam logic [2:0] LAST_IDX    = 3'd7;

    // Operation codes.
    localparam logic [2:0] OP_WRITE_PIXEL  = 3'd0;
    localparam logic [2:0] OP_TOGGLE_PIXEL = 3'd1;
    localparam logic [2:0] OP_WRITE_ROW    = 3'd2;
    localparam logic [2:0] OP_FILL         = 3'd3;
    localparam logic [2:0] OP_CLEAR        = 3'd4;
    localparam logic [2:0] OP_RENDER       = 3'd5;
    localparam logic [2:0] OP_READ_PIXEL   = 3'd6;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] column;
        logic [7:0] row;
        logic       pixel_on;
        logic [7:0] row_bits;
        logic       force_req;
    } t_in_beat;

    typedef struct packed {
        logic       row_write;
        logic [2:0] panel_row;
        logic [7:0] panel_bits;
        logic       pixel_state;
        logic       dirty_flag;
        logic       last;
    } t_out_beat;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // an input beat is taken this cycle
        logic step;     // send the next pending panel row this cycle
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic start_render;  // the accepted beat needs the row sequencer
        logic last_row;      // the row sent on this step is the final one
    } t_status;

endpackage

// ===== rtl/rlmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlmf_ctrl
// Handshake and row sequencing control for the framebuffer.
// ----------------------------------------------------------------------------
module rlmf_ctrl
    import rlmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RENDER = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_slot_free;

    // The output register can take a new beat when empty or being drained.
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign o_in_stall   = (r_state != S_IDLE) || !w_slot_free;
    assign o_cmd.accept = i_in_valid && !o_in_stall;
    assign o_cmd.step   = (r_state == S_RENDER) && w_slot_free;
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    if (i_status.start_render) begin
                        n_state = S_RENDER;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_RENDER: begin
                if (o_cmd.step) begin
                    n_out_valid = 1'b1;
                    if (i_status.last_row) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/rlmf_dp.sv =====
// ----------------------------------------------------------------------------
// rlmf_dp
// Back and front buffers, rotation network, row mask and output register.
// ----------------------------------------------------------------------------
module rlmf_dp
    import rlmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_data,
    output t_status   o_status,
    output t_out_beat o_out_data
);

    logic [7:0] r_back  [NUM_ROWS];
    logic [7:0] n_back  [NUM_ROWS];
    logic [7:0] r_front [NUM_ROWS];
    logic [7:0] n_front [NUM_ROWS];
    logic [7:0] w_rot   [NUM_ROWS];
    logic       r_pend, n_pend;
    logic [1:0] r_rot;
    logic [7:0] r_mask, n_mask;
    t_out_beat  r_out, n_out;

    logic [7:0] w_diff;
    logic [7:0] w_start_mask;
    logic       w_happen;
    logic       w_inside;
    logic [2:0] w_ri;
    logic [2:0] w_ci;
    logic [7:0] w_old;
    logic [7:0] w_bit;
    logic [7:0] w_new;
    logic [7:0] w_fill;
    logic [2:0] w_idx;

    // Rotation network: each panel pixel picks its back-buffer source.
    for (genvar gy = 0; gy < NUM_ROWS; gy++) begin : g_row
        for (genvar gx = 0; gx < NUM_ROWS; gx++) begin : g_col
            localparam logic [2:0] Y  = 3'(gy);
            localparam logic [2:0] X  = 3'(gx);
            localparam logic [2:0] IY = LAST_IDX - 3'(gy);
            localparam logic [2:0] IX = LAST_IDX - 3'(gx);
            always_comb begin
                case (r_rot)
                    2'd1:    w_rot[Y][X] = r_back[IX][Y];
                    2'd2:    w_rot[Y][X] = r_back[IY][IX];
                    2'd3:    w_rot[Y][X] = r_back[X][IY];
                    default: w_rot[Y][X] = r_back[Y][X];
                endcase
            end
        end
        assign w_diff[gy] = (w_rot[gy] != r_front[gy]);
    end

    assign w_inside = (i_in_data.column[7:3] == 5'd0) && (i_in_data.row[7:3] == 5'd0);
    assign w_ri     = i_in_data.row[2:0];
    assign w_ci     = i_in_data.column[2:0];
    assign w_old    = r_back[w_ri];
    assign w_bit    = 8'd1 << w_ci;
    assign w_new    = i_in_data.pixel_on ? (w_old | w_bit) : (w_old & ~w_bit);
    assign w_fill   = i_in_data.pixel_on ? ROW_ALL_ON : ROW_ALL_OFF;

    assign w_happen     = r_pend || i_in_data.force_req;
    assign w_start_mask = !w_happen ? ROW_ALL_OFF
                        : (i_in_data.force_req ? ROW_ALL_ON : w_diff);

    assign o_status.start_render = (i_in_data.operation == OP_CLEAR)
        || ((i_in_data.operation == OP_RENDER) && (w_start_mask != ROW_ALL_OFF));
    assign o_status.last_row = ((r_mask & (r_mask - 8'd1)) == 8'd0);

    // Lowest pending row goes out first.
    always_comb begin
        w_idx = 3'd0;
        for (int k = NUM_ROWS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                w_idx = 3'(k);
            end
        end
    end

    always_comb begin
        n_back  = r_back;
        n_front = r_front;
        n_pend  = r_pend;
        n_mask  = r_mask;
        n_out   = r_out;
        if (i_cmd.accept) begin
            n_out.row_write   = 1'b0;
            n_out.panel_row   = 3'd0;
            n_out.panel_bits  = 8'd0;
            n_out.pixel_state = 1'b0;
            n_out.last        = 1'b1;
            case (i_in_data.operation)
                OP_WRITE_PIXEL: begin
                    if (w_inside) begin
                        n_back[w_ri] = w_new;
                        if (w_new != w_old) begin
                            n_pend = 1'b1;
                        end
                    end
                end
                OP_TOGGLE_PIXEL: begin
                    if (w_inside) begin
                        n_back[w_ri] = w_old ^ w_bit;
                        n_pend       = 1'b1;
                    end
                end
                OP_WRITE_ROW: begin
                    if ((i_in_data.row[7:3] == 5'd0) && (w_old != i_in_data.row_bits)) begin
                        n_back[w_ri] = i_in_data.row_bits;
                        n_pend       = 1'b1;
                    end
                end
                OP_FILL: begin
                    for (int r = 0; r < NUM_ROWS; r++) begin
                        if (r_back[r] != w_fill) begin
                            n_back[r] = w_fill;
                            n_pend    = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int r = 0; r < NUM_ROWS; r++) begin
                        n_back[r]  = ROW_ALL_OFF;
                        n_front[r] = ROW_ALL_OFF;
                    end
                    n_mask = ROW_ALL_ON;
                    n_pend = 1'b0;
                end
                OP_RENDER: begin
                    n_mask = w_start_mask;
                    if (w_happen) begin
                        n_pend = 1'b0;
                    end
                end
                OP_READ_PIXEL: begin
                    n_out.pixel_state = w_inside && w_old[w_ci];
                end
                default: begin
                end
            endcase
            n_out.dirty_flag = n_pend;
        end else if (i_cmd.step) begin
            n_front[w_idx]    = w_rot[w_idx];
            n_mask[w_idx]     = 1'b0;
            n_out.row_write   = 1'b1;
            n_out.panel_row   = w_idx;
            n_out.panel_bits  = w_rot[w_idx];
            n_out.pixel_state = 1'b0;
            n_out.dirty_flag  = r_pend;
            n_out.last        = o_status.last_row;
        end
        if (i_cfg_we) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_back[r]  <= ROW_ALL_OFF;
                r_front[r] <= ROW_ALL_OFF;
            end
            r_pend <= 1'b0;
            r_rot  <= 2'd0;
            r_mask <= ROW_ALL_OFF;
        end else begin
            r_back  <= n_back;
            r_front <= n_front;
            r_pend  <= n_pend;
            r_mask  <= n_mask;
            if (i_cfg_we) begin
                r_rot <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/rotating_led_matrix_framebuffer.sv =====
// ----------------------------------------------------------------------------
// rotating_led_matrix_framebuffer
// Double-buffered 8x8 one-bit LED framebuffer with rotated, incremental render.
// ----------------------------------------------------------------------------
// Pixel, row, fill and read operations each answer with a single result
// beat; a new input beat is taken every cycle while no rows are being sent
// and the output register is free or being drained. After a render or a
// clear is accepted, the row sequencer walks a mask of the rows to send from
// the lowest index up, loading one row beat into the output register at
// each step that the output allows; the input stalls until it has loaded
// the final row beat. A render that finds nothing to send answers with one
// beat that carries no row. Writing the rotation register marks the buffer
// dirty, so the next render redraws the panel at the new angle. The user
// must see that the register is written only while the block is idle; the
// block does not enforce it. After reset both buffers are blank and the dirty flag is clear.
// ----------------------------------------------------------------------------
module rotating_led_matrix_framebuffer
    import rlmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Operation beats.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_data,
    // Result beats toward the panel driver.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_beat  o_out_data,
    // Rotation register write.
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // The controller owns the handshakes and the render sequence state.
    rlmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds both buffers, the rotation network and the
    // output register that carries each result beat.
    rlmf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

endmodule

// ===== rtl/rlmf_checker.sv =====
// ----------------------------------------------------------------------------
// rlmf_props
// Port-level checks of the framebuffer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rlmf_props
    import rlmf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    // A held result beat stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed while stalled");

    // No new work is taken while a result waits in a stalled output register.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input accepted while output register is blocked");

    // A beat without a panel row is always the only beat of its operation.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.row_write) |-> o_out_data.last)
        else $error("non-row result beat without last");

    // Panel rows come only from a render or a clear, which leave the buffer clean.
    a_row_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.row_write)
            |-> (!o_out_data.dirty_flag && !o_out_data.pixel_state))
        else $error("panel row beat shows dirty flag or pixel value");

endmodule

bind rotating_led_matrix_framebuffer rlmf_props u_rlmf_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
